// File: rtl/dda_grid_raycast_column_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the grid raycaster
// Implication checks, same cycle and next cycle, sampled on clk.
// ----------------------------------------------------------------------------
`ifndef DDA_GRID_RAYCAST_COLUMN_CORE_MACROS_SVH
`define DDA_GRID_RAYCAST_COLUMN_CORE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define DDAGR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define DDAGR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ddagr_pkg.sv
// ----------------------------------------------------------------------------
// ddagr_pkg
// Types and constants shared by the raycaster modules.
// ----------------------------------------------------------------------------
package ddagr_pkg;

  localparam int DIV_DW = 31;  // dividend and quotient bits
  localparam int DIV_VW = 41;  // divisor bits
  localparam int DIV_CW = 5;

  localparam logic [40:0] DIST_BIG     = 41'h100_0000_0000;
  localparam logic [23:0] COLOUR_SIDE0 = 24'hFF0000;
  localparam logic [23:0] COLOUR_SIDE1 = 24'h00FF00;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CAST  = 1'b1;

  localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd0;
  localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd1;
  localparam logic [2:0] REG_POS_X         = 3'd2;
  localparam logic [2:0] REG_POS_Y         = 3'd3;
  localparam logic [2:0] REG_DIR_X         = 3'd4;
  localparam logic [2:0] REG_DIR_Y         = 3'd5;
  localparam logic [2:0] REG_PLANE_X       = 3'd6;
  localparam logic [2:0] REG_PLANE_Y       = 3'd7;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CAM,
    S_MULX,
    S_MULY,
    S_RAYY,
    S_DX,
    S_PREY,
    S_DY,
    S_SIDEX,
    S_SIDEY,
    S_STEP,
    S_TEST,
    S_HDIV,
    S_ROWS
  } state_t;

  typedef struct packed {
    logic              start;
    logic [DIV_DW-1:0] dividend;
    logic [DIV_VW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIV_DW-1:0] quot;
  } div_rsp_t;

endpackage

// File: rtl/ddagr_div.sv
// ----------------------------------------------------------------------------
// ddagr_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ddagr_div import ddagr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DIV_CW-1:0] cnt_r;
  logic              done_r;
  logic [DIV_VW-1:0] acc_r;
  logic [DIV_DW-1:0] q_r;
  logic [DIV_VW-1:0] dvs_r;
  logic [DIV_VW:0]   trial;

  assign trial = {acc_r, q_r[DIV_DW-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        cnt_r <= DIV_CW'(DIV_DW);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CW'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc_r <= '0;
      q_r   <= req.dividend;
      dvs_r <= req.divisor;
    end else if (cnt_r != '0) begin
      if (trial >= {1'b0, dvs_r}) begin
        acc_r <= DIV_VW'(trial - {1'b0, dvs_r});
        q_r   <= {q_r[DIV_DW-2:0], 1'b1};
      end else begin
        acc_r <= trial[DIV_VW-1:0];
        q_r   <= {q_r[DIV_DW-2:0], 1'b0};
      end
    end
  end

  assign rsp.busy = (cnt_r != '0);
  assign rsp.done = done_r;
  assign rsp.quot = q_r;

endmodule

// File: rtl/ddagr_map.sv
// ----------------------------------------------------------------------------
// ddagr_map
// Map cell store, one write port and one registered read port.
// ----------------------------------------------------------------------------
module ddagr_map import ddagr_pkg::*; #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic          wdata,
  input  logic [AW-1:0] raddr,
  output logic          rdata
);

  logic mem [DEPTH];
  logic rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/dda_grid_raycast_column_core.sv
// One item at a time; busy is high while a cast runs. The shared divider serves
// the camera term, the two deltas and the height, and the step/read loop runs
// through S_STEP and S_TEST and the registered read port of the map memory.
// After reset the map is cleared, all MAP_DIM*MAP_DIM cells, with busy high.
// ----------------------------------------------------------------------------
// dda_grid_raycast_column_core
// Grid raycaster: map cell writes and one DDA ray cast per screen column.
// ----------------------------------------------------------------------------
`include "dda_grid_raycast_column_core_macros.svh"

module dda_grid_raycast_column_core import ddagr_pkg::*; #(
  parameter int MAP_DIM       = 64,
  parameter int MAX_STEPS     = 128,
  parameter int POS_FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_operation,
  input  logic [10:0]        in_column,
  input  logic [5:0]         in_cell_row,
  input  logic [5:0]         in_cell_col,
  input  logic               in_wall_flag,
  output logic               out_valid,
  output logic [10:0]        out_column,
  output logic               out_hit_found,
  output logic               out_hit_side,
  output logic signed [7:0]  out_hit_cell_x,
  output logic signed [7:0]  out_hit_cell_y,
  output logic [15:0]        out_wall_height,
  output logic [10:0]        out_draw_top,
  output logic [10:0]        out_draw_bottom,
  output logic [23:0]        out_slice_colour,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int DEPTH = MAP_DIM * MAP_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int CIW   = $clog2(MAP_DIM);
  localparam int CW    = (POS_FRAC_BITS >= 22) ? 12 : (34 - POS_FRAC_BITS);
  localparam int SCW   = $clog2(MAX_STEPS + 1);

  // configuration registers
  logic [11:0]        scr_w_r, scr_h_r;
  logic [21:0]        pos_x_r, pos_y_r;
  logic signed [15:0] dir_x_r, dir_y_r, plane_x_r, plane_y_r;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_w_r   <= 12'd800;
      scr_h_r   <= 12'd600;
      pos_x_r   <= 22'd98304;
      pos_y_r   <= 22'd98304;
      dir_x_r   <= -16'sd16384;
      dir_y_r   <= 16'sd0;
      plane_x_r <= 16'sd0;
      plane_y_r <= 16'sd10813;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_SCREEN_WIDTH:  scr_w_r   <= pwdata[11:0];
        REG_SCREEN_HEIGHT: scr_h_r   <= pwdata[11:0];
        REG_POS_X:         pos_x_r   <= pwdata[21:0];
        REG_POS_Y:         pos_y_r   <= pwdata[21:0];
        REG_DIR_X:         dir_x_r   <= pwdata[15:0];
        REG_DIR_Y:         dir_y_r   <= pwdata[15:0];
        REG_PLANE_X:       plane_x_r <= pwdata[15:0];
        REG_PLANE_Y:       plane_y_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_SCREEN_WIDTH:  prdata = {20'd0, scr_w_r};
      REG_SCREEN_HEIGHT: prdata = {20'd0, scr_h_r};
      REG_POS_X:         prdata = {10'd0, pos_x_r};
      REG_POS_Y:         prdata = {10'd0, pos_y_r};
      REG_DIR_X:         prdata = {16'd0, dir_x_r};
      REG_DIR_Y:         prdata = {16'd0, dir_y_r};
      REG_PLANE_X:       prdata = {16'd0, plane_x_r};
      REG_PLANE_Y:       prdata = {16'd0, plane_y_r};
      default:           prdata = '0;
    endcase
  end

  logic [11:0] w_eff, h_eff;
  assign w_eff = (scr_w_r == '0) ? 12'd1 : scr_w_r;
  assign h_eff = (scr_h_r == '0) ? 12'd1 : scr_h_r;

  // datapath registers
  state_t             state_r, state_nxt;
  logic [10:0]        col_r;
  logic               cam_neg_r;
  logic signed [27:0] cam_r;
  logic signed [43:0] prod_r;
  logic signed [31:0] rx_r, ry_r;
  logic [40:0]        dx_r, dy_r, sx_r, sy_r;
  logic signed [CW-1:0] cx_r, cy_r;
  logic [SCW-1:0]     cnt_r;
  logic               side_r, oob_r, hit_r;
  logic [15:0]        lh_r;
  logic [AW-1:0]      clr_r;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // cast setup terms
  logic signed [13:0] cam_num;
  logic [12:0]        cam_mag;
  logic [30:0]        rx_mag, ry_mag;
  logic [24:0]        one, frac_x, frac_y, part_x, part_y;
  logic [55:0]        sprod_x, sprod_y;
  logic signed [31:0] ray_sum;

  assign cam_num = $signed({2'b00, in_column, 1'b0}) - $signed({2'b00, w_eff});
  assign cam_mag = cam_num[13] ? 13'(-cam_num) : cam_num[12:0];
  assign ray_sum = 32'(prod_r >>> 14);
  assign rx_mag  = rx_r[31] ? 31'(-rx_r) : rx_r[30:0];
  assign ry_mag  = ry_r[31] ? 31'(-ry_r) : ry_r[30:0];
  assign one     = 25'd1 << POS_FRAC_BITS;
  assign frac_x  = {3'b000, pos_x_r} & (one - 25'd1);
  assign frac_y  = {3'b000, pos_y_r} & (one - 25'd1);
  assign part_x  = rx_r[31] ? frac_x : (one - frac_x);
  assign part_y  = ry_r[31] ? frac_y : (one - frac_y);
  assign sprod_x = 56'(part_x) * 56'(dx_r[30:0]);
  assign sprod_y = 56'(part_y) * 56'(dy_r[30:0]);

  // walk step
  logic                 x_first;
  logic [41:0]          sx_sum, sy_sum;
  logic signed [CW-1:0] cx_n, cy_n;
  logic                 oob_n;
  logic [AW-1:0]        rd_addr, wr_addr;
  logic [40:0]          perp;
  logic                 wall;
  logic                 map_rd;

  assign x_first = (sx_r < sy_r);
  assign sx_sum  = {1'b0, sx_r} + {1'b0, dx_r};
  assign sy_sum  = {1'b0, sy_r} + {1'b0, dy_r};
  assign cx_n    = !x_first ? cx_r : (rx_r[31] ? cx_r - 1'b1 : cx_r + 1'b1);
  assign cy_n    = x_first ? cy_r : (ry_r[31] ? cy_r - 1'b1 : cy_r + 1'b1);
  assign oob_n   = (cx_n < 0) || (cx_n >= MAP_DIM) || (cy_n < 0) || (cy_n >= MAP_DIM);
  assign rd_addr = AW'(32'(cy_n[CIW-1:0]) * MAP_DIM + 32'(cx_n[CIW-1:0]));
  assign wall    = oob_r | map_rd;
  assign perp    = side_r ? (sy_r - dy_r) : (sx_r - dx_r);

  // map write port: clearing pass or write item
  logic map_we, map_wd, wr_ok, accept;
  logic [AW-1:0] map_wa;

  assign accept  = start & ~busy;
  assign wr_addr = AW'(32'(in_cell_row) * MAP_DIM + 32'(in_cell_col));
  assign wr_ok   = (int'(in_cell_row) < MAP_DIM) && (int'(in_cell_col) < MAP_DIM);

  always_comb begin
    if (state_r == S_CLEAR) begin
      map_we = 1'b1;
      map_wa = clr_r;
      map_wd = 1'b0;
    end else begin
      map_we = accept && (in_operation == OP_WRITE) && wr_ok;
      map_wa = wr_addr;
      map_wd = in_wall_flag;
    end
  end

  ddagr_map #(.DEPTH(DEPTH), .AW(AW)) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_wa),
    .wdata (map_wd),
    .raddr (rd_addr),
    .rdata (map_rd)
  );

  ddagr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    div_req      = '0;
    case (state_r)
      S_CLEAR: begin
        if (clr_r == AW'(DEPTH - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept && in_operation == OP_CAST) begin
          div_req.start    = 1'b1;
          div_req.dividend = 31'({cam_mag, 14'd0});
          div_req.divisor  = 41'(w_eff);
          state_nxt        = S_CAM;
        end
      end
      S_CAM:  if (div_rsp.done) state_nxt = S_MULX;
      S_MULX: state_nxt = S_MULY;
      S_MULY: state_nxt = S_RAYY;
      S_RAYY: begin
        if (rx_r != '0) begin
          div_req.start    = 1'b1;
          div_req.dividend = 31'h4000_0000;
          div_req.divisor  = 41'(rx_mag);
          state_nxt        = S_DX;
        end else begin
          state_nxt = S_PREY;
        end
      end
      S_DX: if (div_rsp.done) state_nxt = S_PREY;
      S_PREY: begin
        if (ry_r != '0) begin
          div_req.start    = 1'b1;
          div_req.dividend = 31'h4000_0000;
          div_req.divisor  = 41'(ry_mag);
          state_nxt        = S_DY;
        end else begin
          state_nxt = S_SIDEX;
        end
      end
      S_DY:    if (div_rsp.done) state_nxt = S_SIDEX;
      S_SIDEX: state_nxt = S_SIDEY;
      S_SIDEY: state_nxt = S_STEP;
      S_STEP:  state_nxt = S_TEST;
      S_TEST: begin
        if (wall) begin
          if (perp == '0) begin
            state_nxt = S_ROWS;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = 31'({h_eff, 16'd0});
            div_req.divisor  = perp;
            state_nxt        = S_HDIV;
          end
        end else if (cnt_r == SCW'(MAX_STEPS)) begin
          state_nxt = S_ROWS;
        end else begin
          state_nxt = S_STEP;
        end
      end
      S_HDIV: if (div_rsp.done) state_nxt = S_ROWS;
      S_ROWS: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_r <= clr_r + 1'b1;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        col_r     <= in_column;
        cam_neg_r <= cam_num[13];
      end
      S_CAM: begin
        cam_r <= cam_neg_r ? -$signed({2'b00, div_rsp.quot[25:0]})
                           : $signed({2'b00, div_rsp.quot[25:0]});
      end
      S_MULX: prod_r <= plane_x_r * cam_r;
      S_MULY: begin
        rx_r   <= 32'(dir_x_r) + ray_sum;
        prod_r <= plane_y_r * cam_r;
      end
      S_RAYY: begin
        ry_r <= 32'(dir_y_r) + ray_sum;
        if (rx_r == '0) dx_r <= DIST_BIG;
      end
      S_DX: dx_r <= 41'(div_rsp.quot);
      S_PREY: if (ry_r == '0) dy_r <= DIST_BIG;
      S_DY: dy_r <= 41'(div_rsp.quot);
      S_SIDEX: begin
        sx_r  <= (rx_r == '0) ? DIST_BIG : 41'(sprod_x >> POS_FRAC_BITS);
        cx_r  <= $signed(CW'(pos_x_r >> POS_FRAC_BITS));
        cy_r  <= $signed(CW'(pos_y_r >> POS_FRAC_BITS));
        cnt_r <= '0;
      end
      S_SIDEY: sy_r <= (ry_r == '0) ? DIST_BIG : 41'(sprod_y >> POS_FRAC_BITS);
      S_STEP: begin
        // advance the nearer axis, y on ties
        if (x_first) begin
          sx_r   <= (sx_sum > 42'(DIST_BIG)) ? DIST_BIG : sx_sum[40:0];
          side_r <= 1'b0;
        end else begin
          sy_r   <= (sy_sum > 42'(DIST_BIG)) ? DIST_BIG : sy_sum[40:0];
          side_r <= 1'b1;
        end
        cx_r  <= cx_n;
        cy_r  <= cy_n;
        oob_r <= oob_n;
        cnt_r <= cnt_r + 1'b1;
      end
      S_TEST: begin
        hit_r <= wall;
        lh_r  <= 16'hFFFF;
      end
      S_HDIV: lh_r <= (div_rsp.quot > 31'd65535) ? 16'hFFFF : div_rsp.quot[15:0];
      default: ;
    endcase
  end

  // slice rows
  logic signed [17:0] top_s;
  logic [17:0]        bot_u;
  logic [10:0]        top_c, bot_c;

  assign top_s = $signed({7'd0, h_eff[11:1]}) - $signed({3'd0, lh_r[15:1]});
  assign bot_u = {3'd0, lh_r[15:1]} + {7'd0, h_eff[11:1]};

  always_comb begin
    if (top_s < 0) top_c = '0;
    else if (top_s > 18'sd2047) top_c = 11'd2047;
    else top_c = top_s[10:0];
    if (bot_u >= 18'(h_eff)) begin
      bot_c = (h_eff > 12'd2048) ? 11'd2047 : 11'(h_eff - 12'd1);
    end else if (bot_u > 18'd2047) begin
      bot_c = 11'd2047;
    end else begin
      bot_c = bot_u[10:0];
    end
  end

  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= (state_r == S_ROWS);
  end

  always_ff @(posedge clk) begin
    if (state_r == S_ROWS) begin
      out_column       <= col_r;
      out_hit_found    <= hit_r;
      out_hit_side     <= hit_r & side_r;
      out_hit_cell_x   <= hit_r ? cx_r[7:0] : '0;
      out_hit_cell_y   <= hit_r ? cy_r[7:0] : '0;
      out_wall_height  <= hit_r ? lh_r : '0;
      out_draw_top     <= hit_r ? top_c : '0;
      out_draw_bottom  <= hit_r ? bot_c : '0;
      out_slice_colour <= !hit_r ? '0 : (side_r ? COLOUR_SIDE1 : COLOUR_SIDE0);
    end
  end

  assign out_valid = out_valid_r;

  `DDAGR_ASSERT_IMP(a_strobe_idle, out_valid, !busy, "result beat while busy")
  `DDAGR_ASSERT_NXT(a_strobe_single, out_valid, !out_valid, "result beat longer than one cycle")
  `DDAGR_ASSERT_IMP(a_div_free, div_req.start, !div_rsp.busy, "divider restarted while running")
  `DDAGR_ASSERT_IMP(a_miss_zero, out_valid && !out_hit_found,
                    out_wall_height == '0 && out_slice_colour == '0, "miss beat not cleared")

endmodule

// File: bench/tb_dda_grid_raycast_column_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dda_grid_raycast_column_core
// Self-checking bench for the grid raycaster. Loads map cells, programs the
// view over the register port, casts columns and checks every result beat
// against an in-bench DDA predictor kept in a small scoreboard class.
// ----------------------------------------------------------------------------
module tb_dda_grid_raycast_column_core;
  import ddagr_pkg::*;

  typedef struct {
    logic [10:0] column;
    logic        hit_found;
    logic        hit_side;
    logic [7:0]  cell_x;
    logic [7:0]  cell_y;
    logic [15:0] height;
    logic [10:0] top;
    logic [10:0] bottom;
    logic [23:0] colour;
  } slice_t;

  class ray_scoreboard;
    bit     wall_map [0:4095];
    longint scr_w, scr_h, px, py, dx, dy, plx, ply;
    slice_t slices_due[$];
    int     errors, casts, writes, hits, side1_hits, sat_heights;

    function new();
      foreach (wall_map[i]) wall_map[i] = 1'b0;
      scr_w = 800; scr_h = 600; px = 98304; py = 98304;
      dx = -16384; dy = 0; plx = 0; ply = 10813;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
        REG_SCREEN_WIDTH:  scr_w = v[11:0];
        REG_SCREEN_HEIGHT: scr_h = v[11:0];
        REG_POS_X:         px = v[21:0];
        REG_POS_Y:         py = v[21:0];
        REG_DIR_X:         dx = longint'($signed(v[15:0]));
        REG_DIR_Y:         dy = longint'($signed(v[15:0]));
        REG_PLANE_X:       plx = longint'($signed(v[15:0]));
        REG_PLANE_Y:       ply = longint'($signed(v[15:0]));
        default: ;
      endcase
    endfunction

    function bit blocked(longint cx, longint cy);
      if (cx < 0 || cy < 0 || cx > 63 || cy > 63) return 1'b1;
      return wall_map[cy * 64 + cx];
    endfunction

    function void axis_init(longint ray, longint pos, output longint stp,
                            output longint dl, output longint sd);
      longint frac, mag, part;
      frac = pos & 64'hFFFF;
      mag  = ray < 0 ? -ray : ray;
      stp  = ray < 0 ? -1 : 1;
      part = ray < 0 ? frac : 65536 - frac;
      if (mag == 0) begin
        dl = DIST_BIG;
        sd = DIST_BIG;
      end else begin
        dl = (longint'(1) << 30) / mag;
        sd = (part * dl) >> 16;
        if (sd > DIST_BIG) sd = DIST_BIG;
      end
    endfunction

    function slice_t trace_column(logic [10:0] col);
      slice_t s;
      longint w, h, cam, rx, ry, sx, sy, ddx, ddy, stx, sty, cx, cy, perp, lh, top, bot;
      bit side, hit;
      w = scr_w == 0 ? 1 : scr_w;
      h = scr_h == 0 ? 1 : scr_h;
      cam = ((2 * longint'(col) - w) * 16384) / w;
      rx = dx + ((plx * cam) >>> 14);
      ry = dy + ((ply * cam) >>> 14);
      cx = px >> 16;
      cy = py >> 16;
      axis_init(rx, px, stx, ddx, sx);
      axis_init(ry, py, sty, ddy, sy);
      side = 0;
      hit = 0;
      for (int n = 0; n < 128 && !hit; n++) begin
        if (sx < sy) begin
          sx = sx + ddx > DIST_BIG ? DIST_BIG : sx + ddx;
          cx += stx;
          side = 0;
        end else begin
          sy = sy + ddy > DIST_BIG ? DIST_BIG : sy + ddy;
          cy += sty;
          side = 1;
        end
        hit = blocked(cx, cy);
      end
      s = '{default: '0};
      s.column = col;
      if (!hit) return s;
      perp = side ? sy - ddy : sx - ddx;
      if (perp <= 0) lh = 65535;
      else begin
        lh = (h << 16) / perp;
        if (lh > 65535) lh = 65535;
      end
      top = h / 2 - lh / 2;
      if (top < 0) top = 0;
      bot = lh / 2 + h / 2;
      if (bot >= h) bot = h - 1;
      if (top > 2047) top = 2047;
      if (bot > 2047) bot = 2047;
      s.hit_found = 1'b1;
      s.hit_side  = side;
      s.cell_x    = cx[7:0];
      s.cell_y    = cy[7:0];
      s.height    = lh[15:0];
      s.top       = top[10:0];
      s.bottom    = bot[10:0];
      s.colour    = side ? COLOUR_SIDE1 : COLOUR_SIDE0;
      return s;
    endfunction

    // Accepted input beat: update the map or queue the expected slice.
    function void note_item(logic op, logic [10:0] col, logic [5:0] row,
                            logic [5:0] cc, logic wall);
      slice_t s;
      if (op == OP_WRITE) begin
        wall_map[row * 64 + cc] = wall;
        writes++;
      end else begin
        s = trace_column(col);
        slices_due.push_back(s);
        casts++;
        if (s.hit_found) hits++;
        if (s.hit_side) side1_hits++;
        if (s.height == 16'hFFFF) sat_heights++;
      end
    endfunction

    function void cmp(string name, longint e, longint a);
      if (e != a) begin
        $error("%s: expected %0d, got %0d", name, e, a);
        errors++;
      end
    endfunction

    function void check_slice(slice_t got);
      slice_t e;
      if (slices_due.size() == 0) begin
        $error("result beat for column %0d with nothing outstanding", got.column);
        errors++;
        return;
      end
      e = slices_due.pop_front();
      cmp("out_column", e.column, got.column);
      cmp("out_hit_found", e.hit_found, got.hit_found);
      cmp("out_hit_side", e.hit_side, got.hit_side);
      cmp("out_hit_cell_x", e.cell_x, got.cell_x);
      cmp("out_hit_cell_y", e.cell_y, got.cell_y);
      cmp("out_wall_height", e.height, got.height);
      cmp("out_draw_top", e.top, got.top);
      cmp("out_draw_bottom", e.bottom, got.bottom);
      cmp("out_slice_colour", e.colour, got.colour);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_operation = OP_WRITE;
  logic [10:0] in_column = '0;
  logic [5:0] in_cell_row = '0;
  logic [5:0] in_cell_col = '0;
  logic in_wall_flag = 1'b0;
  logic out_valid, out_hit_found, out_hit_side;
  logic [10:0] out_column, out_draw_top, out_draw_bottom;
  logic signed [7:0] out_hit_cell_x, out_hit_cell_y;
  logic [15:0] out_wall_height;
  logic [23:0] out_slice_colour;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  ray_scoreboard sb = new();

  always #6 clk = ~clk;

  dda_grid_raycast_column_core uut (
    .clk, .rst_n, .start, .busy, .in_operation, .in_column, .in_cell_row,
    .in_cell_col, .in_wall_flag, .out_valid, .out_column, .out_hit_found,
    .out_hit_side, .out_hit_cell_x, .out_hit_cell_y, .out_wall_height,
    .out_draw_top, .out_draw_bottom, .out_slice_colour, .psel, .penable,
    .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always @(posedge clk) begin
    slice_t got;
    if (rst_n && out_valid) begin
      got.column    = out_column;
      got.hit_found = out_hit_found;
      got.hit_side  = out_hit_side;
      got.cell_x    = out_hit_cell_x;
      got.cell_y    = out_hit_cell_y;
      got.height    = out_wall_height;
      got.top       = out_draw_top;
      got.bottom    = out_draw_bottom;
      got.colour    = out_slice_colour;
      sb.check_slice(got);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 10) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(20, 80);
  endfunction

  // Drive one beat from a falling edge and hold until the block takes it.
  task automatic push_item(logic op, logic [10:0] col, logic [5:0] row,
                           logic [5:0] cc, logic wall, int gap);
    in_operation = op;
    in_column    = col;
    in_cell_row  = row;
    in_cell_col  = cc;
    in_wall_flag = wall;
    start        = 1'b1;
    do @(posedge clk); while (busy);
    sb.note_item(op, col, row, cc, wall);
    @(negedge clk);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic cast(logic [10:0] col);
    push_item(OP_CAST, col, 6'($urandom), 6'($urandom), 1'($urandom), pick_gap());
  endtask

  task automatic put_cell(int row, int cc, logic wall);
    push_item(OP_WRITE, 11'($urandom), row[5:0], cc[5:0], wall, pick_gap());
  endtask

  task automatic drain();
    start = 1'b0;
    do @(posedge clk); while (sb.slices_due.size() != 0 || busy);
    repeat (8) @(negedge clk);
  endtask

  task automatic reg_write(logic [2:0] idx, logic [31:0] v);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = v;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, v);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_view(int w, int h, int pxv, int pyv, int dxv, int dyv,
                          int plxv, int plyv);
    reg_write(REG_SCREEN_WIDTH, w);
    reg_write(REG_SCREEN_HEIGHT, h);
    reg_write(REG_POS_X, pxv);
    reg_write(REG_POS_Y, pyv);
    reg_write(REG_DIR_X, dxv & 32'hFFFF);
    reg_write(REG_DIR_Y, dyv & 32'hFFFF);
    reg_write(REG_PLANE_X, plxv & 32'hFFFF);
    reg_write(REG_PLANE_Y, plyv & 32'hFFFF);
  endtask

  function automatic int rand_q14();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return -32768;
    if (r == 1) return 32767;
    if (r == 2) return 0;
    return $urandom_range(0, 65535) - 32768;
  endfunction

  function automatic int rand_pos();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom_range(0, 65535);
    if (r == 1) return (63 << 16) | $urandom_range(0, 65535);
    if (r == 2) return 22'h3FFFFF;
    return ($urandom_range(1, 62) << 16) | $urandom_range(0, 65535);
  endfunction

  function automatic int rand_dim();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 1;
      2: return 4095;
      3: return 2048;
      4: return $urandom_range(2, 16);
      default: return $urandom_range(1, 4095);
    endcase
  endfunction

  initial begin
    int w, density;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // Directed: default view, open map except an outer boundary.
    cast(11'd0);
    cast(11'd400);
    cast(11'd799);
    cast(11'd2047);
    put_cell(1, 2, 1'b1);
    put_cell(63, 63, 1'b1);
    put_cell(0, 0, 1'b1);
    cast(11'd400);
    put_cell(1, 2, 1'b0);
    cast(11'd400);
    drain();

    // Zero screen size, zero ray in y, wall right in front for a tiny distance.
    set_view(0, 0, (5 << 16) | 16'hFFF0, (5 << 16) | 16'h8000, 16384, 0, 0, 0);
    put_cell(5, 6, 1'b1);
    cast(11'd0);
    cast(11'd2047);
    drain();
    set_view(1, 4095, (5 << 16) | 16'hFFFF, (5 << 16), 32767, -32768, 32767, 32767);
    cast(11'd0);
    cast(11'd1);
    cast(11'd1365);
    drain();
    set_view(2048, 2048, 32 << 16, 32 << 16, -32768, 32767, -32768, -32768);
    cast(11'd0);
    cast(11'd1024);
    cast(11'd2047);
    put_cell(5, 6, 1'b0);
    drain();

    for (int ph = 0; ph < 14; ph++) begin
      w = rand_dim();
      set_view(w, rand_dim(), rand_pos(), rand_pos(), rand_q14(), rand_q14(),
               rand_q14(), rand_q14());
      density = $urandom_range(0, 40);
      for (int k = 0; k < 52; k++) begin
        if ($urandom_range(0, 99) < 30)
          put_cell($urandom_range(0, 63), $urandom_range(0, 63),
                   $urandom_range(0, 99) < density);
        else if ($urandom_range(0, 3) == 0)
          cast(11'($urandom_range(0, 2047)));
        else
          cast(11'($urandom_range(0, (w > 1 ? w : 2) - 1) % 2048));
      end
      drain();
    end

    repeat (20) @(posedge clk);
    $display("Cast %0d columns and wrote %0d map cells over 18 view settings;",
             sb.casts, sb.writes);
    $display("%0d walls hit, %0d on y crossings, %0d with saturated height.",
             sb.hits, sb.side1_hits, sb.sat_heights);
    if (sb.errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin
    #30_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
